>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the subsequence length block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PMSL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define PMSL_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) trig |=> prop) else $error(msg);

`endif

>>> rtl/pmsl_pkg.sv
// Shared types and constants of the subsequence length block.
`timescale 1ns / 1ps

package pmsl_pkg;

   localparam int RANK_W        = 13;
   localparam int LEN_W         = 13;
   localparam int EPOCH_W       = 4;
   localparam int MAX_RANKS_DEF = 4096;

   localparam logic [LEN_W-1:0]  LEN_MAX     = 13'h1FFF;
   localparam logic [RANK_W-1:0] RANKS_RESET = 13'd4096;

   // request payload
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              new_sequence;
   } req_type;

   // result payload
   typedef struct packed {
      logic [LEN_W-1:0] run_length;
      logic [LEN_W-1:0] best_length;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic clear;
      logic query;
      logic start_update;
      logic update;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_clear;
      logic clear_last;
      logic query_done;
      logic update_done;
      logic rsp_free;
   } stat_type;

endpackage

>>> rtl/pmsl_ctrl.sv
// Sequencer: clear pass, query walk, update walk and result hand-off.
`timescale 1ns / 1ps

module pmsl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pmsl_pkg::stat_type stat,
   output pmsl_pkg::cmd_type  cmd
);
   import pmsl_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_QUERY  = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       pend_ff;
   logic       pend_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.need_clear) begin
                  pend_in  = 1'b1;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_QUERY;
               end
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               pend_in  = 1'b0;
               state_in = pend_ff ? S_QUERY : S_IDLE;
            end
         end
         S_QUERY: begin
            if (stat.query_done) begin
               cmd.start_update = 1'b1;
               state_in         = S_UPDATE;
            end else begin
               cmd.query = 1'b1;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            if (stat.update_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // reset starts with a clear pass over the tree
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

>>> rtl/pmsl_datapath.sv
// Tree memory, walk position, length accumulator and result register.
`timescale 1ns / 1ps

module pmsl_datapath #(
   parameter int MAX_RANKS = pmsl_pkg::MAX_RANKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pmsl_pkg::cmd_type                 cmd,
   output pmsl_pkg::stat_type                stat,
   input  pmsl_pkg::req_type                 req_data,
   input  logic                              csr_wr_en,
   input  logic [pmsl_pkg::RANK_W-1:0]       csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pmsl_pkg::rsp_type                 rsp_data
);
   import pmsl_pkg::*;

   localparam int PW = $clog2(MAX_RANKS + 1);
   localparam int AW = $clog2(MAX_RANKS);
   localparam int CW = (PW > RANK_W) ? PW : RANK_W;

   typedef struct packed {
      logic [EPOCH_W-1:0] ep;
      logic [LEN_W-1:0]   val;
   } entry_type;

   entry_type mem [MAX_RANKS];

   logic [RANK_W-1:0]  ranks_ff,     ranks_in;
   logic [EPOCH_W-1:0] epoch_ff,     epoch_in;
   logic [LEN_W-1:0]   best_ff,      best_in;
   logic [LEN_W-1:0]   acc_ff,       acc_in;
   logic [LEN_W-1:0]   len_ff,       len_in;
   logic [PW-1:0]      r_ff,         r_in;
   logic [PW-1:0]      bound_ff,     bound_in;
   logic [PW:0]        pos_ff,       pos_in;
   logic               rd_pend_ff,   rd_pend_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic [AW-1:0]      clr_ff,       clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff,       rsp_in;
   entry_type          rd_ff;

   logic [CW-1:0]  csr_ext;
   logic [CW-1:0]  rank_ext;
   logic [PW-1:0]  bound_w;
   logic [PW-1:0]  rank_w;
   logic [PW:0]    lowbit;
   logic           pos_nz;
   logic           walk_ok;
   logic [AW-1:0]  rd_addr;
   logic [LEN_W-1:0] rd_eff;
   logic [LEN_W-1:0] acc_max;
   logic [LEN_W-1:0] len_sat;
   logic           clear_last;
   logic           mem_re;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   entry_type      mem_wdata;

   // walk bound and rank, both saturated
   assign csr_ext  = CW'(ranks_ff);
   assign bound_w  = (csr_ext == '0) ? PW'(1) :
                     (csr_ext > CW'(MAX_RANKS)) ? PW'(MAX_RANKS) : PW'(csr_ext);
   assign rank_ext = CW'(req_data.rank);
   assign rank_w   = (rank_ext == '0) ? PW'(1) :
                     (rank_ext > CW'(bound_w)) ? bound_w : PW'(rank_ext);

   // tree walk helpers
   assign lowbit  = pos_ff & (~pos_ff + (PW+1)'(1));
   assign pos_nz  = (pos_ff != '0);
   assign walk_ok = pos_nz && (pos_ff <= {1'b0, bound_ff});
   assign rd_addr = AW'(pos_ff - (PW+1)'(1));

   // entries of an older sequence read as zero
   assign rd_eff  = (rd_ff.ep == epoch_ff) ? rd_ff.val : '0;
   assign acc_max = (rd_pend_ff && (rd_eff > acc_ff)) ? rd_eff : acc_ff;
   assign len_sat = (acc_ff == LEN_MAX) ? LEN_MAX : acc_ff + LEN_W'(1);

   assign clear_last = (clr_ff == AW'(MAX_RANKS - 1));

   // memory port control
   assign mem_re    = (cmd.query && pos_nz) || (cmd.update && walk_ok);
   assign mem_we    = cmd.clear || (cmd.update && rd_pend_ff && (rd_eff < len_ff));
   assign mem_waddr = cmd.clear ? clr_ff : pend_addr_ff;
   assign mem_wdata = '{ep: epoch_ff, val: (cmd.clear ? '0 : len_ff)};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // next values
   always_comb begin
      ranks_in     = ranks_ff;
      epoch_in     = epoch_ff;
      best_in      = best_ff;
      acc_in       = acc_ff;
      len_in       = len_ff;
      r_in         = r_ff;
      bound_in     = bound_ff;
      pos_in       = pos_ff;
      rd_pend_in   = rd_pend_ff;
      pend_addr_in = pend_addr_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_wr_en) begin
         ranks_in = csr_wr_data;
      end

      if (cmd.accept) begin
         r_in       = rank_w;
         bound_in   = bound_w;
         pos_in     = {1'b0, rank_w};
         acc_in     = '0;
         rd_pend_in = 1'b0;
         if (req_data.new_sequence) begin
            best_in  = '0;
            epoch_in = epoch_ff + EPOCH_W'(1);
         end
      end

      if (cmd.clear) begin
         clr_in = clear_last ? '0 : clr_ff + AW'(1);
      end

      // query walks down, one node read per cycle
      if (cmd.query) begin
         if (pos_nz) begin
            pos_in = pos_ff - lowbit;
         end
         rd_pend_in = pos_nz;
         acc_in     = acc_max;
      end

      if (cmd.start_update) begin
         len_in     = len_sat;
         best_in    = (len_sat > best_ff) ? len_sat : best_ff;
         pos_in     = {1'b0, r_ff};
         rd_pend_in = 1'b0;
      end

      // update walks up: read this node, write back the previous one
      if (cmd.update) begin
         if (walk_ok) begin
            pos_in = pos_ff + lowbit;
         end
         rd_pend_in   = walk_ok;
         pend_addr_in = rd_addr;
      end

      // result register
      if (cmd.load_rsp) begin
         rsp_in       = '{run_length: len_ff, best_length: best_ff};
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ranks_ff     <= RANKS_RESET;
         epoch_ff     <= '0;
         best_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ranks_ff     <= ranks_in;
         epoch_ff     <= epoch_in;
         best_ff      <= best_in;
         rd_pend_ff   <= rd_pend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      len_ff       <= len_in;
      r_ff         <= r_in;
      bound_ff     <= bound_in;
      pos_ff       <= pos_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   // status to the sequencer
   assign stat.need_clear  = req_data.new_sequence && (&epoch_ff);
   assign stat.clear_last  = clear_last;
   assign stat.query_done  = !pos_nz && !rd_pend_ff;
   assign stat.update_done = !walk_ok && !rd_pend_ff;
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/prefix_max_subsequence_length_top.sv
// Top level of the longest non-decreasing subsequence block.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Longest non-decreasing subsequence over a stream of one-based ranks, kept in a
// prefix-maximum Fenwick tree in one simple dual-port memory (one read and one
// write per cycle). One request is worked on at a time: a query walk down the
// tree reads one node per cycle, then an update walk up the tree reads one node
// per cycle and writes back the node read the cycle before. A finished result
// sits in an output register, so the next request is taken while it waits.
// new_sequence bumps a 4-bit sequence tag kept with each entry, so old entries
// read as zero. After reset, and on every 16th new_sequence when the tag wraps,
// a clearing pass writes all MAX_RANKS entries, one per cycle, before the
// request goes on; no request is taken during it. The rank bound register may
// be written at any time the block is idle.
module prefix_max_subsequence_length_top #(
   parameter int MAX_RANKS = pmsl_pkg::MAX_RANKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pmsl_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pmsl_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [pmsl_pkg::RANK_W-1:0] csr_wr_data
);
   import pmsl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pmsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pmsl_datapath #(
      .MAX_RANKS (MAX_RANKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // sequencer drives at most one command per cycle
   `PMSL_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
   // one request at a time
   `PMSL_ASSERT_NEXT(a_no_b2b, req_valid && req_ready, !req_ready, "request taken twice")
   // a waiting result is never overwritten
   `PMSL_ASSERT(a_no_overwrite, cmd.load_rsp |-> (!rsp_valid || rsp_ready), "result lost")
   // running best never below the current length
   `PMSL_ASSERT(a_best_ge_run, rsp_valid |-> (rsp_data.best_length >= rsp_data.run_length), "best low")

endmodule
